// ===== hw/rtl/tlg_pkg.sv =====
// Shared types, constants and helpers for the tremolo LFO gain stage.
// No dependencies; every other RTL file imports this package.
`default_nettype none
package tlg_pkg;

	localparam int SAMPLE_BITS_DEF = 32;
	localparam int QUEUE_DEPTH_DEF = 2;

	// register indexes (byte address / 4)
	localparam logic [2:0] REG_INPUT_GAIN    = 3'd0;
	localparam logic [2:0] REG_DEPTH         = 3'd1;
	localparam logic [2:0] REG_WAVEFORM      = 3'd2;
	localparam logic [2:0] REG_PHASE_STEP    = 3'd3;
	localparam logic [2:0] REG_FOUR_CHANNELS = 3'd4;

	localparam logic [31:0] RST_INPUT_GAIN = 32'd1352914698;
	localparam logic [30:0] RST_DEPTH      = 31'h7FFF_FFFF;
	localparam logic [1:0]  RST_WAVEFORM   = 2'd1;
	localparam logic [30:0] RST_PHASE_STEP = 31'd44739;

	// waveform codes
	localparam logic [1:0] WAVE_TRIANGLE = 2'd0;
	localparam logic [1:0] WAVE_SQUARE   = 2'd1;
	localparam logic [1:0] WAVE_SLOPED   = 2'd2;

	// Q0.31 phase points and unity
	localparam logic [31:0] ONE_Q31     = 32'h8000_0000;
	localparam logic [30:0] PH_QUARTER  = 31'd536870912;
	localparam logic [30:0] PH_HALF     = 31'd1073741824;
	localparam logic [30:0] PH_3QUARTER = 31'd1610612736;
	localparam logic [30:0] PH_048      = 31'd1030792151;
	localparam logic [30:0] PH_098      = 31'd2104533975;
	localparam logic [5:0]  EDGE_SLOPE  = 6'd50;

	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	typedef struct packed {
		logic signed [31:0] input_gain;
		logic [30:0]        depth;
		logic [1:0]         waveform;
		logic [30:0]        phase_step;
		logic               four_channels;
	} tlg_cfg_t;

	// one frame between front and back
	typedef struct packed {
		logic signed [31:0] left;
		logic signed [31:0] right;
		logic [30:0]        factor;
		logic               side_en;
	} tlg_entry_t;

	typedef struct packed {
		logic empty;
		logic full;
		logic last;   // exactly one item held
	} tlg_qstat_t;

	// floor(p / 2^31) saturated to Q1.31
	function automatic logic signed [31:0] sat_q31(input logic signed [63:0] p);
		logic signed [63:0] sh;
		sh = p >>> 31;
		if (sh > SAT_MAX)
			return SAT_MAX[31:0];
		else if (sh < SAT_MIN)
			return SAT_MIN[31:0];
		else
			return sh[31:0];
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/tlg_front.sv =====
// Front end: takes frames, applies the sample mask, evaluates the LFO and
// the tremolo factor, and hands entries to the queue. Uses tlg_pkg.
`default_nettype none
module tlg_front
	import tlg_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [31:0] left_sample,
	input  wire logic signed [31:0] right_sample,
	input  wire tlg_cfg_t           cfg,
	input  wire tlg_qstat_t         qstat,
	output logic                    q_push,
	output tlg_entry_t              q_data
);

	localparam logic [31:0] KeepMask = 32'hFFFF_FFFF << (32 - SAMPLE_BITS);

	logic               valid_s1;
	logic signed [31:0] left_s1;
	logic signed [31:0] right_s1;
	logic [31:0]        lfo_s1;
	logic               side_s1;
	logic [30:0]        phase_q;

	logic        accept;
	logic [31:0] lfo_now;
	logic [62:0] dl_prod;
	logic [31:0] m_val;
	logic [31:0] fac32;

	function automatic logic [31:0] edge_val(input logic [30:0] p, input logic [30:0] base);
		logic [30:0] d;
		d = p - base;
		return 32'(d[25:0]) * 32'(EDGE_SLOPE);
	endfunction

	always_comb begin
		logic [31:0] e;
		lfo_now = '0;
		e = '0;
		case (cfg.waveform)
			WAVE_TRIANGLE: begin
				if (phase_q < PH_QUARTER)
					lfo_now = {1'b0, PH_HALF} + {phase_q, 1'b0};
				else if (phase_q < PH_3QUARTER)
					lfo_now = ONE_Q31 - {phase_q - PH_QUARTER, 1'b0};
				else
					lfo_now = {phase_q - PH_3QUARTER, 1'b0};
			end
			WAVE_SQUARE: begin
				lfo_now = (phase_q < PH_HALF) ? ONE_Q31 : 32'd0;
			end
			WAVE_SLOPED: begin
				if (phase_q < PH_048) begin
					lfo_now = ONE_Q31;
				end else if (phase_q < PH_HALF) begin
					e = edge_val(phase_q, PH_048);
					lfo_now = (e >= ONE_Q31) ? 32'd0 : ONE_Q31 - e;
				end else if (phase_q < PH_098) begin
					lfo_now = 32'd0;
				end else begin
					e = edge_val(phase_q, PH_098);
					lfo_now = (e > ONE_Q31) ? ONE_Q31 : e;
				end
			end
			default: begin
				lfo_now = 32'd0;
			end
		endcase
	end

	assign full   = valid_s1 && qstat.full;
	assign accept = push && !full;
	assign q_push = valid_s1 && !qstat.full;

	// factor = 1 - depth*lfo, held below one
	assign dl_prod = 63'(cfg.depth) * 63'(lfo_s1);
	assign m_val   = dl_prod[62:31];
	assign fac32   = ONE_Q31 - m_val;

	always_comb begin
		q_data.left    = left_s1;
		q_data.right   = right_s1;
		q_data.side_en = side_s1;
		q_data.factor  = (m_val == 32'd0) ? 31'h7FFF_FFFF : fac32[30:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= '0;
		end else begin
			if (accept) begin
				valid_s1 <= 1'b1;
				if (cfg.four_channels)
					phase_q <= phase_q + cfg.phase_step;
			end else if (q_push) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			left_s1  <= left_sample & KeepMask;
			right_s1 <= right_sample & KeepMask;
			lfo_s1   <= lfo_now;
			side_s1  <= cfg.four_channels;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tlg_queue.sv =====
// Short FIFO of frame entries between the front and back ends.
// Uses tlg_pkg for the entry and status types.
`default_nettype none
module tlg_queue
	import tlg_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       wr_en,
	input  wire tlg_entry_t wr_data,
	input  wire logic       rd_en,
	output tlg_entry_t      rd_data,
	output tlg_qstat_t      stat
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

	tlg_entry_t      mem_q [DEPTH];
	logic [PtrW-1:0] wptr_q;
	logic [PtrW-1:0] rptr_q;
	logic [CntW-1:0] count_q;

	logic do_wr;
	logic do_rd;

	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == FullCnt);
	assign stat.last  = (count_q == CntW'(1));
	assign do_wr      = wr_en && !stat.full;
	assign do_rd      = rd_en && !stat.empty;
	assign rd_data    = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_wr)
				wptr_q <= (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
			if (do_rd)
				rptr_q <= (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
			if (do_wr && !do_rd)
				count_q <= count_q + 1'b1;
			else if (do_rd && !do_wr)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wptr_q] <= wr_data;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tlg_back.sv =====
// Back end: one shared 32x32 multiplier stepped through gain and tremolo
// products, then an output register with empty/pop. Uses tlg_pkg.
`default_nettype none
module tlg_back
	import tlg_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire tlg_cfg_t           cfg,
	input  wire tlg_entry_t         head,
	input  wire tlg_qstat_t         qstat,
	output logic                    q_pop,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      left_out,
	output logic signed [31:0]      right_out,
	output logic signed [31:0]      left_side,
	output logic signed [31:0]      right_side
);

	localparam logic [31:0] KeepMask = 32'hFFFF_FFFF << (32 - SAMPLE_BITS);

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_RUN  = 3'b010,
		B_HOLD = 3'b100
	} back_state_t;

	localparam logic [1:0] STEP_GL = 2'd0;
	localparam logic [1:0] STEP_GR = 2'd1;
	localparam logic [1:0] STEP_SL = 2'd2;
	localparam logic [1:0] STEP_SR = 2'd3;

	back_state_t        state_q;
	logic [1:0]         step_q;
	logic signed [31:0] gl_q;
	logic signed [31:0] gr_q;
	logic signed [31:0] sl_q;
	logic signed [31:0] sr_q;
	logic               out_valid_q;

	logic signed [31:0] op_a;
	logic signed [31:0] op_b;
	logic signed [63:0] prod;
	logic signed [31:0] res;
	logic               slot_free;
	logic               xfer;

	always_comb begin
		op_a = head.left;
		op_b = cfg.input_gain;
		case (step_q)
			STEP_GL: begin
				op_a = head.left;
				op_b = cfg.input_gain;
			end
			STEP_GR: begin
				op_a = head.right;
				op_b = cfg.input_gain;
			end
			STEP_SL: begin
				op_a = gl_q;
				op_b = {1'b0, head.factor};
			end
			STEP_SR: begin
				op_a = gr_q;
				op_b = {1'b0, head.factor};
			end
			default: begin
				op_a = head.left;
				op_b = cfg.input_gain;
			end
		endcase
	end

	assign prod      = 64'(op_a) * 64'(op_b);
	assign res       = sat_q31(prod);
	assign slot_free = !out_valid_q || pop;
	assign xfer      = (state_q == B_HOLD) && slot_free;
	assign q_pop     = xfer;
	assign empty     = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			step_q      <= STEP_GL;
			out_valid_q <= 1'b0;
		end else begin
			if (xfer)
				out_valid_q <= 1'b1;
			else if (pop)
				out_valid_q <= 1'b0;
			case (state_q)
				B_IDLE: begin
					if (!qstat.empty) begin
						state_q <= B_RUN;
						step_q  <= STEP_GL;
					end
				end
				B_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_SR)
						state_q <= B_HOLD;
				end
				B_HOLD: begin
					// go straight on when another item waits behind this one
					if (slot_free) begin
						state_q <= qstat.last ? B_IDLE : B_RUN;
						step_q  <= STEP_GL;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == B_RUN) begin
			case (step_q)
				STEP_GL: gl_q <= res;
				STEP_GR: gr_q <= res;
				STEP_SL: sl_q <= res;
				STEP_SR: sr_q <= res;
				default: gl_q <= res;
			endcase
		end
		if (xfer) begin
			left_out   <= gl_q & KeepMask;
			right_out  <= gr_q & KeepMask;
			left_side  <= head.side_en ? (sl_q & KeepMask) : 32'sd0;
			right_side <= head.side_en ? (sr_q & KeepMask) : 32'sd0;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tremolo_lfo_gain_stage.sv =====
// Tremolo LFO gain stage, top level: APB register file, front end, queue, back end.
// The back end makes four passes through its single multiplier per item, then hands
// it over to the output register; the front end and queue accept new frames meanwhile.
// Reset (arst_n, asynchronous): registers to defaults, LFO phase zero, the queue empty.
// Depends on tlg_pkg, tlg_front, tlg_queue and tlg_back.
`default_nettype none
module tremolo_lfo_gain_stage
	import tlg_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               push,
	output logic                    full,
	input  wire logic signed [31:0] left_sample,
	input  wire logic signed [31:0] right_sample,
	output logic                    empty,
	input  wire logic               pop,
	output logic signed [31:0]      left_out,
	output logic signed [31:0]      right_out,
	output logic signed [31:0]      left_side,
	output logic signed [31:0]      right_side,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [4:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	tlg_cfg_t   cfg_q;
	tlg_qstat_t qstat;
	tlg_entry_t q_wr_data;
	tlg_entry_t q_head;
	logic       q_push;
	logic       q_pop;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite && pready;
	assign reg_idx = paddr[4:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.input_gain    <= RST_INPUT_GAIN;
			cfg_q.depth         <= RST_DEPTH;
			cfg_q.waveform      <= RST_WAVEFORM;
			cfg_q.phase_step    <= RST_PHASE_STEP;
			cfg_q.four_channels <= 1'b1;
		end else if (wr_en) begin
			case (reg_idx)
				REG_INPUT_GAIN:    cfg_q.input_gain    <= pwdata;
				REG_DEPTH:         cfg_q.depth         <= pwdata[30:0];
				REG_WAVEFORM:      cfg_q.waveform      <= pwdata[1:0];
				REG_PHASE_STEP:    cfg_q.phase_step    <= pwdata[30:0];
				REG_FOUR_CHANNELS: cfg_q.four_channels <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_INPUT_GAIN:    prdata = cfg_q.input_gain;
			REG_DEPTH:         prdata = {1'b0, cfg_q.depth};
			REG_WAVEFORM:      prdata = {30'd0, cfg_q.waveform};
			REG_PHASE_STEP:    prdata = {1'b0, cfg_q.phase_step};
			REG_FOUR_CHANNELS: prdata = {31'd0, cfg_q.four_channels};
			default:           prdata = 32'd0;
		endcase
	end

	tlg_front #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.left_sample (left_sample),
		.right_sample(right_sample),
		.cfg         (cfg_q),
		.qstat       (qstat),
		.q_push      (q_push),
		.q_data      (q_wr_data)
	);

	tlg_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_data(q_wr_data),
		.rd_en  (q_pop),
		.rd_data(q_head),
		.stat   (qstat)
	);

	tlg_back #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.head      (q_head),
		.qstat     (qstat),
		.q_pop     (q_pop),
		.empty     (empty),
		.pop       (pop),
		.left_out  (left_out),
		.right_out (right_out),
		.left_side (left_side),
		.right_side(right_side)
	);

endmodule
`default_nettype wire

// ===== dv/tb_tremolo_lfo_gain_stage.sv =====
// Self-checking testbench for tremolo_lfo_gain_stage: APB register writes, stereo frames
// in, gained and tremolo frames out, each checked against a bit-true model of the stage.
// Depends on tlg_pkg and the RTL of the stage; needs nothing else.
module tb_tremolo_lfo_gain_stage;
	import tlg_pkg::*;

	localparam int SAMPLE_BITS = 32;
	localparam int IDLE_LIMIT = 3000;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 10;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_FRAMES = 125;

	localparam logic [2:0] REG_UNMAPPED = 3'd5;
	localparam logic [1:0] WAVE_NONE = 2'd3;

	// LFO levels and phase points, Q0.31 held in 64 bits
	localparam logic signed [63:0] LFO_ONE = 64'sd2147483648;
	localparam logic signed [63:0] PT_QUARTER = 64'sd536870912;
	localparam logic signed [63:0] PT_HALF = 64'sd1073741824;
	localparam logic signed [63:0] PT_3QUARTER = 64'sd1610612736;
	localparam logic signed [63:0] PT_FALL = 64'sd1030792151;
	localparam logic signed [63:0] PT_RISE = 64'sd2104533975;
	localparam logic signed [63:0] SLOPE = 64'sd50;
	localparam logic [31:0] KEEP_MASK = 32'hFFFF_FFFF << (32 - SAMPLE_BITS);

	// [0] left_out, [1] right_out, [2] left_side, [3] right_side
	typedef logic [3:0][31:0] frame_t;

	class tremolo_tracker;
		logic signed [31:0] gain;
		logic [30:0]        depth;
		logic [1:0]         wave;
		logic [30:0]        step;
		logic               four_ch;
		logic [30:0]        phase;
		frame_t             frames_due[$];
		int                 errors;

		function new();
			gain = 32'sd1352914698;
			depth = 31'h7FFF_FFFF;
			wave = WAVE_SQUARE;
			step = 31'd44739;
			four_ch = 1'b1;
			phase = '0;
			errors = 0;
		endfunction

		function void apply_write(logic [4:0] addr, logic [31:0] data);
			case (addr[4:2])
				REG_INPUT_GAIN: gain = data;
				REG_DEPTH: depth = data[30:0];
				REG_WAVEFORM: wave = data[1:0];
				REG_PHASE_STEP: step = data[30:0];
				REG_FOUR_CHANNELS: four_ch = data[0];
				default: ;
			endcase
		endfunction

		function logic [31:0] keep_top(logic [31:0] v);
			return v & KEEP_MASK;
		endfunction

		// floor(a*b / 2^31), saturated to Q1.31
		function logic signed [31:0] scale_q31(logic signed [63:0] a, logic signed [63:0] b);
			logic signed [63:0] q;
			q = (a * b) >>> 31;
			if (q > 64'sd2147483647)
				return 32'h7FFF_FFFF;
			if (q < -64'sd2147483648)
				return 32'h8000_0000;
			return q[31:0];
		endfunction

		function logic signed [63:0] lfo_level(logic [30:0] p);
			logic signed [63:0] ph;
			logic signed [63:0] v;
			ph = {33'd0, p};
			case (wave)
				WAVE_TRIANGLE: begin
					if (ph < PT_QUARTER)
						v = PT_HALF + 2 * ph;
					else if (ph < PT_3QUARTER)
						v = LFO_ONE - 2 * (ph - PT_QUARTER);
					else
						v = 2 * (ph - PT_3QUARTER);
				end
				WAVE_SQUARE: v = (ph < PT_HALF) ? LFO_ONE : 64'sd0;
				WAVE_SLOPED: begin
					if (ph < PT_FALL)
						v = LFO_ONE;
					else if (ph < PT_HALF)
						v = LFO_ONE - SLOPE * (ph - PT_FALL);
					else if (ph < PT_RISE)
						v = 64'sd0;
					else
						v = SLOPE * (ph - PT_RISE);
				end
				default: v = 64'sd0;
			endcase
			// edges may overshoot the unit range
			if (v < 0)
				v = 0;
			else if (v > LFO_ONE)
				v = LFO_ONE;
			return v;
		endfunction

		function void take_frame(logic [31:0] left, logic [31:0] right);
			logic signed [31:0] l, r, gl, gr;
			logic [31:0]        ls, rs;
			logic [63:0]        lvl, m, factor;
			frame_t             f;
			l = keep_top(left);
			r = keep_top(right);
			gl = scale_q31(l, gain);
			gr = scale_q31(r, gain);
			ls = '0;
			rs = '0;
			if (four_ch) begin
				lvl = lfo_level(phase);
				m = ({33'd0, depth} * lvl) >> 31;
				factor = 64'h8000_0000 - m;
				if (factor > 64'h7FFF_FFFF)
					factor = 64'h7FFF_FFFF;
				ls = keep_top(scale_q31(gl, factor));
				rs = keep_top(scale_q31(gr, factor));
				phase = phase + step;
			end
			f[0] = keep_top(gl);
			f[1] = keep_top(gr);
			f[2] = ls;
			f[3] = rs;
			frames_due.push_back(f);
		endfunction

		function void match_frame(frame_t got);
			frame_t want;
			string  name;
			if (frames_due.size() == 0) begin
				errors++;
				$display("%0t: result expected none, got %h", $time, got);
				return;
			end
			want = frames_due.pop_front();
			for (int i = 0; i < 4; i++) begin
				if (got[i] !== want[i]) begin
					case (i)
						0: name = "left_out";
						1: name = "right_out";
						2: name = "left_side";
						default: name = "right_side";
					endcase
					errors++;
					$display("%0t: %s expected %0d got %0d", $time, name,
						$signed(want[i]), $signed(got[i]));
				end
			end
		endfunction

		function int pending();
			return frames_due.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic signed [31:0] left_sample = '0;
	logic signed [31:0] right_sample = '0;
	logic               empty;
	logic               pop = 1'b0;
	logic signed [31:0] left_out;
	logic signed [31:0] right_out;
	logic signed [31:0] left_side;
	logic signed [31:0] right_side;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [4:0]         paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	tremolo_tracker tracker;
	bit             no_idle = 1'b0;
	bit             hold_rx = 1'b0;
	int             idle_cycles = 0;

	tremolo_lfo_gain_stage #(.SAMPLE_BITS(SAMPLE_BITS)) dut (.*);

	always #6 clk = ~clk;

	function automatic int next_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic offer(input logic [31:0] l, input logic [31:0] r);
		int gap;
		gap = next_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		left_sample <= l;
		right_sample <= r;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	// hold the input until every item has come out
	task automatic drain();
		push <= 1'b0;
		@(posedge clk);
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// one item with a chosen step brings the phase to target
	task automatic align_phase(input logic [30:0] target);
		logic [30:0] delta;
		drain();
		delta = target - tracker.phase;
		reg_write(REG_PHASE_STEP, {1'b0, delta});
		offer(rand_sample(), rand_sample());
		drain();
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty)
				tracker.match_frame({right_side, left_side, right_out, left_out});
			if (push && !full)
				tracker.take_frame(left_sample, right_sample);
			if (psel && penable && pwrite && pready)
				tracker.apply_write(paddr, pwdata);
			if ((pop && !empty) || (push && !full) || (psel && penable && pwrite && pready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin : receiver
		int gap;
		wait (arst_n);
		forever begin
			if (hold_rx) begin
				pop <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_rx = 1'b0;
			end
			gap = next_gap();
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	initial begin : sender
		int          pick;
		logic [31:0] value;
		logic [2:0]  ri;
		tracker = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: square LFO at full depth
		offer(32'h8000_0000, 32'h7FFF_FFFF);
		offer(32'h0000_0000, 32'hFFFF_FFFF);
		offer(32'h7FFF_FFFF, 32'h8000_0000);

		// gain of minus one; minus one squared saturates
		drain();
		reg_write(REG_INPUT_GAIN, 32'h8000_0000);
		offer(32'h8000_0000, 32'h8000_0000);
		offer(32'h7FFF_FFFF, 32'h0000_0001);

		// triangle at its corner points
		drain();
		reg_write(REG_INPUT_GAIN, 32'h7FFF_FFFF);
		reg_write(REG_WAVEFORM, 32'(WAVE_TRIANGLE));
		align_phase(31'd0);
		reg_write(REG_PHASE_STEP, 32'd536870912);
		repeat (4) offer(rand_sample(), rand_sample());

		// sloped square, both ends of each edge
		drain();
		reg_write(REG_WAVEFORM, 32'(WAVE_SLOPED));
		align_phase(31'd1030792151);
		reg_write(REG_PHASE_STEP, 32'd42949672);
		repeat (2) offer(rand_sample(), rand_sample());
		align_phase(31'd2104533975);
		reg_write(REG_PHASE_STEP, 32'd42949672);
		repeat (2) offer(rand_sample(), rand_sample());

		// undefined waveform gives no tremolo
		drain();
		reg_write(REG_WAVEFORM, 32'(WAVE_NONE));
		repeat (2) offer(rand_sample(), rand_sample());

		// stereo only: sides zero, phase holds
		drain();
		reg_write(REG_FOUR_CHANNELS, 32'h0);
		repeat (2) offer(rand_sample(), rand_sample());

		// write to an unmapped index is dropped
		drain();
		reg_write(REG_UNMAPPED, $urandom);
		reg_write(REG_FOUR_CHANNELS, 32'h1);
		reg_write(REG_WAVEFORM, 32'(WAVE_SQUARE));
		offer(rand_sample(), rand_sample());

		drain();
		reg_write(REG_DEPTH, 32'h0);
		reg_write(REG_PHASE_STEP, 32'h0);
		offer(rand_sample(), rand_sample());

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			drain();
			no_idle = 1'b0;
			for (int idx = 0; idx <= 5; idx++) begin
				ri = 3'(idx);
				pick = $urandom_range(0, 7);
				value = $urandom;
				case (ri)
					REG_INPUT_GAIN: begin
						if (pick == 0)
							value = 32'h8000_0000;
						else if (pick == 1)
							value = 32'h7FFF_FFFF;
						else if (pick == 2)
							value = 32'h0;
					end
					REG_DEPTH: begin
						if (pick == 0)
							value = 32'h0;
						else if (pick == 1)
							value = 32'hFFFF_FFFF;
					end
					REG_PHASE_STEP: begin
						// mostly slow steps so the LFO is swept finely
						if (pick < 4)
							value[30:20] = '0;
						else if (pick == 4)
							value = 32'h0;
						else if (pick == 5)
							value = 32'hFFFF_FFFF;
					end
					REG_FOUR_CHANNELS: begin
						if (pick != 0)
							value[0] = 1'b1;
					end
					default: ;
				endcase
				reg_write(ri, value);
			end
			no_idle = (ph == 2);
			if (ph == 4)
				hold_rx = 1'b1;
			for (int n = 0; n < PHASE_FRAMES; n++)
				offer(rand_sample(), rand_sample());
		end

		drain();
		if (tracker.errors == 0 && tracker.pending() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/tlg_pkg.sv
hw/rtl/tlg_front.sv
hw/rtl/tlg_queue.sv
hw/rtl/tlg_back.sv
hw/rtl/tremolo_lfo_gain_stage.sv
dv/tb_tremolo_lfo_gain_stage.sv
